### design/lpfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared types and constants for the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package lpfd_pkg;

  // Event codes carried on each result
  typedef enum logic [2:0] {
    EV_HDR_BYTE  = 3'd0,
    EV_HDR_OK    = 3'd1,
    EV_PAY_BYTE  = 3'd2,
    EV_OVERSIZE  = 3'd3,
    EV_REFUSED   = 3'd4,
    EV_CLEARED   = 3'd5
  } event_t;

  // Request kinds
  typedef enum logic {
    KIND_BYTE  = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_t;

  localparam int unsigned HDR_LAST          = 15;
  localparam int unsigned HDR_CNT_W         = 4;
  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd65536;

endpackage

### design/lpfd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfd_in_if / lpfd_out_if
// Valid/ready channels for the byte stream and the deframed results.
// ----------------------------------------------------------------------------
interface lpfd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface lpfd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [15:0] frame_channel;
  logic [7:0]  message_type;
  logic [7:0]  frame_flags;
  logic [31:0] sequence_res;
  logic [31:0] correlation;
  logic [31:0] payload_length;
  logic [7:0]  payload_byte;
  logic        frame_end;
  logic        error_flag;

  modport source (output valid, output event_res, output frame_channel, output message_type,
                  output frame_flags, output sequence_res, output correlation,
                  output payload_length, output payload_byte, output frame_end,
                  output error_flag, input ready);
  modport sink   (input valid, input event_res, input frame_channel, input message_type,
                  input frame_flags, input sequence_res, input correlation,
                  input payload_length, input payload_byte, input frame_end,
                  input error_flag, output ready);
endinterface

### design/length_prefixed_frame_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_top
// Gathers a 16-byte little-endian header from a byte stream and streams the
// payload bytes out tagged with the decoded header fields.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : one request per byte (kind = byte) or a clear (kind = clear).
//   out_chan : exactly one result per request, in request order.
//   cfg_we / cfg_wdata : write max_payload; only while the block is idle.
// Each request's result is loaded into the output register when the request
// is taken. One request is taken per cycle while the receiver takes results;
// the only storage in the path is the result register, so in_chan.ready is high
// whenever that register is empty or is being emptied in the same cycle.
// If the receiver stalls, the result is held and in_chan.ready stays low for
// every cycle that out_chan.ready stays low.
// Reset (rst, synchronous) returns to the header phase with the error flag
// clear and max_payload at 65536. A clear request does the same but keeps
// max_payload. After an oversize length all bytes are refused until a clear.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer_top (
  input  logic              clk,
  input  logic              rst,
  lpfd_in_if.sink           in_chan,
  lpfd_out_if.source        out_chan,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata
);
  import lpfd_pkg::*;

  // Parser state
  logic                 phase_payload, phase_payload_next;
  logic [HDR_CNT_W-1:0] header_count, header_count_next;
  logic [31:0]          payload_count, payload_count_next;
  logic                 sticky_error, sticky_error_next;
  logic [7:0]           hdr_store [HDR_LAST];
  logic [31:0]          max_payload;

  // Decoded header of the current frame
  logic [15:0] chan, chan_next;
  logic [7:0]  mtype, mtype_next;
  logic [7:0]  flags, flags_next;
  logic [31:0] seq, seq_next;
  logic [31:0] corr, corr_next;
  logic [31:0] len, len_next;

  // Result register
  logic        out_valid;
  event_t      res_event;
  logic        res_hdr;
  logic [7:0]  res_pbyte;
  logic        res_end;
  logic [15:0] o_chan;
  logic [7:0]  o_mtype;
  logic [7:0]  o_flags;
  logic [31:0] o_seq;
  logic [31:0] o_corr;
  logic [31:0] o_len;
  logic [7:0]  o_pbyte;
  logic        o_end;
  logic        o_err;
  event_t      o_event;

  logic        accept;
  logic        hdr_write;
  logic [31:0] pay_inc;

  assign in_chan.ready = !out_valid || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign pay_inc       = payload_count + 32'd1;

  // Next state and result for the request at the input
  always_comb begin
    phase_payload_next = phase_payload;
    header_count_next  = header_count;
    payload_count_next = payload_count;
    sticky_error_next  = sticky_error;
    chan_next          = chan;
    mtype_next         = mtype;
    flags_next         = flags;
    seq_next           = seq;
    corr_next          = corr;
    len_next           = len;
    res_event          = EV_REFUSED;
    res_hdr            = 1'b0;
    res_pbyte          = 8'd0;
    res_end            = 1'b0;
    hdr_write          = 1'b0;

    if (in_chan.kind == KIND_CLEAR) begin
      phase_payload_next = 1'b0;
      header_count_next  = '0;
      payload_count_next = '0;
      sticky_error_next  = 1'b0;
      chan_next          = '0;
      mtype_next         = '0;
      flags_next         = '0;
      seq_next           = '0;
      corr_next          = '0;
      len_next           = '0;
      res_event          = EV_CLEARED;
    end else if (sticky_error) begin
      res_event = EV_REFUSED;
    end else if (!phase_payload) begin
      if (header_count != HDR_CNT_W'(HDR_LAST)) begin
        // header byte, stored in place
        hdr_write         = 1'b1;
        header_count_next = header_count + 1'b1;
        res_event         = EV_HDR_BYTE;
      end else begin
        // last header byte: decode and check the length
        chan_next         = {hdr_store[1], hdr_store[0]};
        mtype_next        = hdr_store[2];
        flags_next        = hdr_store[3];
        seq_next          = {hdr_store[7], hdr_store[6],
                             hdr_store[5], hdr_store[4]};
        corr_next         = {hdr_store[11], hdr_store[10],
                             hdr_store[9], hdr_store[8]};
        len_next          = {in_chan.data_byte, hdr_store[14],
                             hdr_store[13], hdr_store[12]};
        header_count_next = '0;
        res_hdr           = 1'b1;
        if (len_next > max_payload) begin
          sticky_error_next = 1'b1;
          res_event         = EV_OVERSIZE;
        end else begin
          payload_count_next = '0;
          res_event          = EV_HDR_OK;
          if (len_next == 32'd0) begin
            res_end = 1'b1;
          end else begin
            phase_payload_next = 1'b1;
          end
        end
      end
    end else begin
      // payload byte
      res_event          = EV_PAY_BYTE;
      res_hdr            = 1'b1;
      res_pbyte          = in_chan.data_byte;
      payload_count_next = pay_inc;
      if (pay_inc >= len) begin
        res_end            = 1'b1;
        phase_payload_next = 1'b0;
        payload_count_next = '0;
      end
    end
  end

  // Control state, header fields and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_payload <= 1'b0;
      header_count  <= '0;
      payload_count <= '0;
      sticky_error  <= 1'b0;
      chan          <= '0;
      mtype         <= '0;
      flags         <= '0;
      seq           <= '0;
      corr          <= '0;
      len           <= '0;
      max_payload   <= MAX_PAYLOAD_RESET;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_payload <= cfg_wdata;
      end
      if (accept) begin
        phase_payload <= phase_payload_next;
        header_count  <= header_count_next;
        payload_count <= payload_count_next;
        sticky_error  <= sticky_error_next;
        chan          <= chan_next;
        mtype         <= mtype_next;
        flags         <= flags_next;
        seq           <= seq_next;
        corr          <= corr_next;
        len           <= len_next;
        out_valid     <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      o_event <= res_event;
      o_chan  <= res_hdr ? chan_next  : 16'd0;
      o_mtype <= res_hdr ? mtype_next : 8'd0;
      o_flags <= res_hdr ? flags_next : 8'd0;
      o_seq   <= res_hdr ? seq_next   : 32'd0;
      o_corr  <= res_hdr ? corr_next  : 32'd0;
      o_len   <= res_hdr ? len_next   : 32'd0;
      o_pbyte <= res_pbyte;
      o_end   <= res_end;
      o_err   <= sticky_error_next;
    end
  end

  // Header byte store; every entry is written before it is read
  always_ff @(posedge clk) begin
    if (accept && hdr_write) begin
      hdr_store[header_count] <= in_chan.data_byte;
    end
  end

  assign out_chan.valid          = out_valid;
  assign out_chan.event_res      = o_event;
  assign out_chan.frame_channel  = o_chan;
  assign out_chan.message_type   = o_mtype;
  assign out_chan.frame_flags    = o_flags;
  assign out_chan.sequence_res   = o_seq;
  assign out_chan.correlation    = o_corr;
  assign out_chan.payload_length = o_len;
  assign out_chan.payload_byte   = o_pbyte;
  assign out_chan.frame_end      = o_end;
  assign out_chan.error_flag     = o_err;

endmodule
